// ----- hdl/aabb_sq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_sq_pkg: shared types and constants for the box store
// Capacity, coordinate width, command and status codes, box type, control
// and status bundles between controller and datapath, overlap test.
// ----------------------------------------------------------------------------
package aabb_sq_pkg;

  localparam int CAPACITY   = 8;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int HANDLE_W   = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_REGION = 2'd2,
    CMD_PAIR   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_CLEARED  = 3'd2,
    ST_OBJECT   = 3'd3,
    ST_PAIR     = 3'd4,
    ST_NO_MATCH = 3'd5
  } status_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
  } box_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic finish_simple;
    logic finish_scan;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic more;
    logic s2_valid;
    logic stall;
  } stat_t;

  function automatic logic box_overlap(box_t a, box_t b);
    return (a.x0 <= b.x1) && (b.x0 <= a.x1) && (a.y0 <= b.y1) && (b.y0 <= a.y1);
  endfunction

endpackage

// ----- hdl/aabb_sq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_sq_if: command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface aabb_sq_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [15:0]        object_handle;
  logic signed [15:0] x_min;
  logic signed [15:0] y_min;
  logic signed [15:0] x_max;
  logic signed [15:0] y_max;

  modport source (
    output valid, command, object_handle, x_min, y_min, x_max, y_max,
    input  ready
  );
  modport sink (
    input  valid, command, object_handle, x_min, y_min, x_max, y_max,
    output ready
  );
endinterface

interface aabb_sq_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] first_handle;
  logic [15:0] second_handle;
  logic        last;

  modport source (
    output valid, status, first_handle, second_handle, last,
    input  ready
  );
  modport sink (
    input  valid, status, first_handle, second_handle, last,
    output ready
  );
endinterface

// ----- hdl/aabb_sq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_sq_ctrl: command sequencer
// Takes one command beat at a time and steps the datapath through the
// store/clear answer or the region/pair scan and its final result.
// ----------------------------------------------------------------------------
module aabb_sq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  logic [1:0]          command_i,
  output logic                cmd_ready_o,
  input  aabb_sq_pkg::stat_t  stat_i,
  output aabb_sq_pkg::ctl_t   ctl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FLUSH
  } state_e;

  state_e state_q;
  logic   accept;
  logic   is_query;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign is_query    = (command_i == aabb_sq_pkg::CMD_REGION) ||
                       (command_i == aabb_sq_pkg::CMD_PAIR);

  always_comb begin
    ctl_o               = '0;
    ctl_o.load          = accept;
    ctl_o.issue         = (state_q == S_SCAN) && stat_i.more && !stat_i.stall;
    ctl_o.finish_simple = (state_q == S_EXEC) && stat_i.slot_free;
    ctl_o.finish_scan   = (state_q == S_FLUSH) && stat_i.slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= is_query ? S_SCAN : S_EXEC;
          end
        end
        S_EXEC: begin
          if (stat_i.slot_free) begin
            state_q <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (!stat_i.more && !stat_i.s2_valid) begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (stat_i.slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/aabb_sq_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_sq_dp: box store datapath
// Box and handle memories, scan indices, one registered read stage with the
// overlap tests, a pending-match register that settles the last flag, and
// the result output register.
// ----------------------------------------------------------------------------
module aabb_sq_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  aabb_sq_pkg::ctl_t                    ctl_i,
  output aabb_sq_pkg::stat_t                   stat_o,
  input  logic [1:0]                           command_i,
  input  logic [aabb_sq_pkg::HANDLE_W-1:0]     object_handle_i,
  input  logic signed [15:0]                   x_min_i,
  input  logic signed [15:0]                   y_min_i,
  input  logic signed [15:0]                   x_max_i,
  input  logic signed [15:0]                   y_max_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output logic [2:0]                           status_o,
  output logic [aabb_sq_pkg::HANDLE_W-1:0]     first_handle_o,
  output logic [aabb_sq_pkg::HANDLE_W-1:0]     second_handle_o,
  output logic                                 last_o
);

  localparam int IW = aabb_sq_pkg::IDX_W;
  localparam int CW = aabb_sq_pkg::CNT_W;
  localparam int HW = aabb_sq_pkg::HANDLE_W;
  localparam int CB = aabb_sq_pkg::COORD_BITS;

  aabb_sq_pkg::box_t    mem_box [aabb_sq_pkg::CAPACITY];
  logic [HW-1:0]        mem_hdl [aabb_sq_pkg::CAPACITY];

  aabb_sq_pkg::cmd_e    cmd_q;
  aabb_sq_pkg::box_t    region_q;
  logic [HW-1:0]        new_hdl_q;
  logic [CW-1:0]        count_q;
  logic [IW-1:0]        outer_q;
  logic [IW-1:0]        inner_q;
  logic                 more_q;

  logic                 s2_valid_q;
  aabb_sq_pkg::box_t    a_q;
  aabb_sq_pkg::box_t    b_q;
  logic [HW-1:0]        ha_q;
  logic [HW-1:0]        hb_q;

  logic                 pend_valid_q;
  logic [HW-1:0]        pend_first_q;
  logic [HW-1:0]        pend_second_q;

  logic                 out_valid_q;
  aabb_sq_pkg::status_e out_status_q;
  logic [HW-1:0]        out_first_q;
  logic [HW-1:0]        out_second_q;
  logic                 out_last_q;

  aabb_sq_pkg::box_t    in_box;
  aabb_sq_pkg::cmd_e    in_cmd;
  logic                 slot_free;
  logic                 is_pair;
  logic                 full;
  logic                 hit;
  logic                 stall;
  logic                 push_out;
  logic [CW-1:0]        outer_inc;
  logic [CW-1:0]        outer_inc2;
  logic [CW-1:0]        inner_inc;
  aabb_sq_pkg::status_e match_status;
  logic [HW-1:0]        match_second;

  assign in_box.x0 = x_min_i[CB-1:0];
  assign in_box.y0 = y_min_i[CB-1:0];
  assign in_box.x1 = x_max_i[CB-1:0];
  assign in_box.y1 = y_max_i[CB-1:0];
  assign in_cmd    = aabb_sq_pkg::cmd_e'(command_i);

  assign slot_free = !out_valid_q || res_ready_i;
  assign is_pair   = (cmd_q == aabb_sq_pkg::CMD_PAIR);
  assign full      = (count_q >= CW'(aabb_sq_pkg::CAPACITY));

  assign hit = s2_valid_q && (is_pair ?
      ((aabb_sq_pkg::box_overlap(region_q, a_q) || aabb_sq_pkg::box_overlap(region_q, b_q))
       && aabb_sq_pkg::box_overlap(a_q, b_q)) :
      aabb_sq_pkg::box_overlap(a_q, region_q));
  assign stall    = hit && pend_valid_q && !slot_free;
  assign push_out = hit && pend_valid_q && slot_free;

  assign match_status = is_pair ? aabb_sq_pkg::ST_PAIR : aabb_sq_pkg::ST_OBJECT;
  assign match_second = is_pair ? hb_q : '0;

  assign outer_inc  = {1'b0, outer_q} + CW'(1);
  assign outer_inc2 = {1'b0, outer_q} + CW'(2);
  assign inner_inc  = {1'b0, inner_q} + CW'(1);

  assign stat_o.slot_free = slot_free;
  assign stat_o.more      = more_q;
  assign stat_o.s2_valid  = s2_valid_q;
  assign stat_o.stall     = stall;

  // command latch
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q     <= in_cmd;
      region_q  <= in_box;
      new_hdl_q <= object_handle_i;
    end
  end

  // store memories
  always_ff @(posedge clk_i) begin
    if (ctl_i.finish_simple && (cmd_q == aabb_sq_pkg::CMD_STORE) && !full) begin
      mem_box[count_q[IW-1:0]] <= region_q;
      mem_hdl[count_q[IW-1:0]] <= new_hdl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.finish_simple) begin
      if (cmd_q == aabb_sq_pkg::CMD_CLEAR) begin
        count_q <= '0;
      end else if (!full) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  // scan indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= '0;
      inner_q <= '0;
      more_q  <= 1'b0;
    end else if (ctl_i.load) begin
      outer_q <= '0;
      if (in_cmd == aabb_sq_pkg::CMD_PAIR) begin
        inner_q <= IW'(1);
        more_q  <= (count_q >= CW'(2));
      end else if (in_cmd == aabb_sq_pkg::CMD_REGION) begin
        inner_q <= '0;
        more_q  <= (count_q != '0);
      end else begin
        inner_q <= '0;
        more_q  <= 1'b0;
      end
    end else if (ctl_i.issue) begin
      if (!is_pair) begin
        outer_q <= outer_inc[IW-1:0];
        more_q  <= (outer_inc < count_q);
      end else if (inner_inc < count_q) begin
        inner_q <= inner_inc[IW-1:0];
      end else begin
        outer_q <= outer_inc[IW-1:0];
        inner_q <= outer_inc2[IW-1:0];
        more_q  <= (outer_inc2 < count_q);
      end
    end else if (ctl_i.finish_scan) begin
      outer_q <= '0;
      inner_q <= '0;
      more_q  <= 1'b0;
    end
  end

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!stall) begin
      s2_valid_q <= ctl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      a_q  <= mem_box[outer_q];
      b_q  <= mem_box[inner_q];
      ha_q <= mem_hdl[outer_q];
      hb_q <= mem_hdl[inner_q];
    end
  end

  // pending match: held until the next match or the end of the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (hit && !stall) begin
      pend_valid_q <= 1'b1;
    end else if (ctl_i.finish_scan) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit && !stall) begin
      pend_first_q  <= ha_q;
      pend_second_q <= match_second;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_out || ctl_i.finish_simple || ctl_i.finish_scan) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (push_out) begin
      out_status_q <= match_status;
      out_first_q  <= pend_first_q;
      out_second_q <= pend_second_q;
      out_last_q   <= 1'b0;
    end else if (ctl_i.finish_simple) begin
      if (cmd_q == aabb_sq_pkg::CMD_CLEAR) begin
        out_status_q <= aabb_sq_pkg::ST_CLEARED;
      end else if (full) begin
        out_status_q <= aabb_sq_pkg::ST_FULL;
      end else begin
        out_status_q <= aabb_sq_pkg::ST_STORED;
      end
      out_first_q  <= '0;
      out_second_q <= '0;
      out_last_q   <= 1'b1;
    end else if (ctl_i.finish_scan) begin
      if (pend_valid_q) begin
        out_status_q <= match_status;
        out_first_q  <= pend_first_q;
        out_second_q <= pend_second_q;
      end else begin
        out_status_q <= aabb_sq_pkg::ST_NO_MATCH;
        out_first_q  <= '0;
        out_second_q <= '0;
      end
      out_last_q <= 1'b1;
    end else begin
      out_status_q <= out_status_q;
    end
  end

  assign res_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign first_handle_o  = out_first_q;
  assign second_handle_o = out_second_q;
  assign last_o          = out_last_q;

endmodule

// ----- hdl/aabb_store_region_and_pair_query.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_store_region_and_pair_query: axis-aligned box store with queries
// Keeps up to CAPACITY boxes with object handles; answers clear, store,
// region query and pair query commands with a stream of result beats.
// ----------------------------------------------------------------------------
// One command beat is taken at a time. Clear and store answer with a single
// beat, written to the output register from the exec state once the result
// slot is free. A region query reads one stored box per cycle and a pair
// query one stored pair per cycle through a single registered read stage and
// overlap compare, except while a held match waits for the result side; the
// scan length is set by the stored count, and the result side can lengthen a
// query by holding ready low. Each match beat is held back one match so the
// final beat carries last; a query with no match ends with a single no-match
// beat.
module aabb_store_region_and_pair_query (
  input  logic              clk_i,
  input  logic              rst_ni,
  aabb_sq_cmd_if.sink       req_i,
  aabb_sq_res_if.source     rsp_o
);

  aabb_sq_pkg::ctl_t  ctl;
  aabb_sq_pkg::stat_t stat;

  aabb_sq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (req_i.valid),
    .command_i   (req_i.command),
    .cmd_ready_o (req_i.ready),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  aabb_sq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .command_i       (req_i.command),
    .object_handle_i (req_i.object_handle),
    .x_min_i         (req_i.x_min),
    .y_min_i         (req_i.y_min),
    .x_max_i         (req_i.x_max),
    .y_max_i         (req_i.y_max),
    .res_valid_o     (rsp_o.valid),
    .res_ready_i     (rsp_o.ready),
    .status_o        (rsp_o.status),
    .first_handle_o  (rsp_o.first_handle),
    .second_handle_o (rsp_o.second_handle),
    .last_o          (rsp_o.last)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for aabb_store_region_and_pair_query
// Sends clear, store, region query and pair query commands with random gaps,
// keeps a shadow copy of the box store to work out the result beats of each
// command, and checks every returned beat in order under random stalls.
// ----------------------------------------------------------------------------
module tb;
  import aabb_sq_pkg::*;

  typedef struct packed {
    cmd_e                command;
    logic [HANDLE_W-1:0] handle;
    box_t                box;
  } order_t;

  typedef struct {
    status_e             status;
    logic [HANDLE_W-1:0] first;
    logic [HANDLE_W-1:0] second;
    logic                last;
  } answer_t;

  logic   clk_i     = 1'b0;
  logic   rst_ni    = 1'b0;
  logic   cmd_valid = 1'b0;
  order_t cmd_word  = '0;
  logic   res_ready = 1'b0;
  logic   cmd_fire  = 1'b0;
  logic   res_fire  = 1'b0;

  box_t                shadow_box    [CAPACITY];
  logic [HANDLE_W-1:0] shadow_handle [CAPACITY];
  int                  shadow_count = 0;
  order_t              orders_pending [$];
  answer_t             answers_due [$];
  int                  fail_count = 0;
  int                  send_gap   = 0;
  int                  take_gap   = 0;
  bit                  send_calm  = 1'b0;
  bit                  take_calm  = 1'b0;

  aabb_sq_cmd_if cmd_bus ();
  aabb_sq_res_if res_bus ();

  assign cmd_bus.valid         = cmd_valid;
  assign cmd_bus.command       = cmd_word.command;
  assign cmd_bus.object_handle = cmd_word.handle;
  assign cmd_bus.x_min         = cmd_word.box.x0;
  assign cmd_bus.y_min         = cmd_word.box.y0;
  assign cmd_bus.x_max         = cmd_word.box.x1;
  assign cmd_bus.y_max         = cmd_word.box.y1;
  assign res_bus.ready         = res_ready;

  aabb_store_region_and_pair_query dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cmd_bus),
    .rsp_o  (res_bus)
  );

  always #6 clk_i = ~clk_i;

  function automatic box_t span(int x0, int y0, int x1, int y1);
    box_t b;
    b.x0 = x0[COORD_BITS-1:0];
    b.y0 = y0[COORD_BITS-1:0];
    b.x1 = x1[COORD_BITS-1:0];
    b.y1 = y1[COORD_BITS-1:0];
    return b;
  endfunction

  function automatic box_t rand_box();
    int pick, cx, cy, w, h;
    pick = $urandom_range(0, 9);
    cx   = $urandom_range(0, 600) - 300;
    cy   = $urandom_range(0, 600) - 300;
    w    = $urandom_range(0, 200);
    h    = $urandom_range(0, 200);
    if (pick < 7) return span(cx, cy, cx + w, cy + h);
    if (pick < 8) return span(cx + w, cy + h, cx, cy);
    return span($urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic void queue_order(cmd_e c, logic [HANDLE_W-1:0] h, box_t b);
    order_t o;
    o.command = c;
    o.handle  = h;
    o.box     = b;
    orders_pending = {orders_pending, o};
  endfunction

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 11) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  function automatic bit boxes_meet(box_t a, box_t b);
    return ($signed(a.x0) <= $signed(b.x1)) && ($signed(b.x0) <= $signed(a.x1)) &&
           ($signed(a.y0) <= $signed(b.y1)) && ($signed(b.y0) <= $signed(a.y1));
  endfunction

  function automatic answer_t make_answer(status_e s, logic [HANDLE_W-1:0] h1,
                                          logic [HANDLE_W-1:0] h2);
    answer_t a;
    a.status = s;
    a.first  = h1;
    a.second = h2;
    a.last   = 1'b0;
    return a;
  endfunction

  function automatic void predict_answers(order_t o);
    answer_t hits [$];
    answer_t a;
    case (o.command)
      CMD_CLEAR: begin
        shadow_count = 0;
        hits = {hits, make_answer(ST_CLEARED, '0, '0)};
      end
      CMD_STORE: begin
        if (shadow_count >= CAPACITY) begin
          hits = {hits, make_answer(ST_FULL, '0, '0)};
        end else begin
          shadow_box[shadow_count]    = o.box;
          shadow_handle[shadow_count] = o.handle;
          shadow_count++;
          hits = {hits, make_answer(ST_STORED, '0, '0)};
        end
      end
      CMD_REGION: begin
        for (int i = 0; i < shadow_count; i++)
          if (boxes_meet(shadow_box[i], o.box))
            hits = {hits, make_answer(ST_OBJECT, shadow_handle[i], '0)};
      end
      default: begin
        for (int i = 0; i + 1 < shadow_count; i++)
          for (int j = i + 1; j < shadow_count; j++)
            if ((boxes_meet(o.box, shadow_box[i]) || boxes_meet(o.box, shadow_box[j])) &&
                boxes_meet(shadow_box[i], shadow_box[j]))
              hits = {hits, make_answer(ST_PAIR, shadow_handle[i], shadow_handle[j])};
      end
    endcase
    if (hits.size() == 0) hits = {hits, make_answer(ST_NO_MATCH, '0, '0)};
    for (int k = 0; k < hits.size(); k++) begin
      a      = hits[k];
      a.last = (k == hits.size() - 1);
      answers_due = {answers_due, a};
    end
  endfunction

  // command driver
  always @(negedge clk_i) begin
    if (rst_ni && !(cmd_valid && !cmd_fire)) begin
      if (cmd_valid) send_gap = draw_wait(send_calm);
      if (send_gap > 0 || orders_pending.size() == 0) begin
        cmd_valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        cmd_word  <= orders_pending.pop_front();
        cmd_valid <= 1'b1;
      end
    end
  end

  // result stall driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_fire) take_gap = draw_wait(take_calm);
      if (take_gap > 0) begin
        res_ready <= 1'b0;
        take_gap--;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // monitor: check result beats, then predict from the command beat
  always @(posedge clk_i) begin : watch
    answer_t want;
    cmd_fire <= cmd_valid && cmd_bus.ready;
    res_fire <= res_bus.valid && res_ready;
    if (rst_ni && res_bus.valid && res_ready) begin
      if (answers_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat: status %0d first %h second %h last %b",
                 $time, res_bus.status, res_bus.first_handle, res_bus.second_handle,
                 res_bus.last);
      end else begin
        want = answers_due.pop_front();
        if (res_bus.status !== want.status || res_bus.first_handle !== want.first ||
            res_bus.second_handle !== want.second || res_bus.last !== want.last) begin
          fail_count++;
          $display("%0t: expected st %0d %h %h last %b, got st %0d %h %h last %b",
                   $time, want.status, want.first, want.second, want.last,
                   res_bus.status, res_bus.first_handle, res_bus.second_handle,
                   res_bus.last);
        end
      end
    end
    if (rst_ni && cmd_valid && cmd_bus.ready) predict_answers(cmd_word);
  end

  initial begin : stimulus
    box_t whole;
    int   pick;
    whole = span(-32768, -32768, 32767, 32767);
    queue_order(CMD_REGION, 16'h0000, whole);
    queue_order(CMD_PAIR, 16'hFFFF, whole);
    queue_order(CMD_STORE, 16'h0000, whole);
    queue_order(CMD_PAIR, 16'h0000, whole);
    queue_order(CMD_STORE, 16'hFFFF, span(0, 0, 16, 16));
    queue_order(CMD_STORE, 16'h1234, span(16, 16, 32, 32));
    queue_order(CMD_STORE, 16'h0005, span(10, 10, -10, -10));
    for (int n = 0; n < 4; n++)
      queue_order(CMD_STORE, 16'($urandom_range(0, 65535)), whole);
    queue_order(CMD_STORE, 16'hBEEF, rand_box());
    queue_order(CMD_REGION, 16'h0000, whole);
    queue_order(CMD_PAIR, 16'h0000, whole);
    queue_order(CMD_REGION, 16'h0000, span(32767, 32767, -32768, -32768));
    queue_order(CMD_REGION, 16'h0000, span(16, 16, 16, 16));
    queue_order(CMD_PAIR, 16'h0000, span(16, 16, 16, 16));
    queue_order(CMD_CLEAR, 16'hFFFF, span($urandom, $urandom, $urandom, $urandom));
    queue_order(CMD_REGION, 16'h0000, whole);

    for (int n = 0; n < 160; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        queue_order(CMD_CLEAR, 16'($urandom), span($urandom, $urandom, $urandom, $urandom));
      else if (pick < 52)
        queue_order(CMD_STORE, 16'($urandom), rand_box());
      else if (pick < 76)
        queue_order(CMD_REGION, 16'($urandom), rand_box());
      else
        queue_order(CMD_PAIR, 16'($urandom), rand_box());
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (orders_pending.size() != 0 || cmd_valid || answers_due.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (fail_count == 0 && answers_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #9_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
